@@ rtl/q_table_learn_select_assert.svh @@
// Assertion macros shared by the checker; they sample clk and honor rst_n.
`ifndef Q_TABLE_LEARN_SELECT_ASSERT_SVH
`define Q_TABLE_LEARN_SELECT_ASSERT_SVH

// Same-cycle implication.
`define QTLS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qtls check failed");

// Next-cycle implication.
`define QTLS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qtls check failed");

`endif

@@ rtl/qtls_pkg.sv @@
`timescale 1ns / 1ps
package qtls_pkg;

    localparam int STATES_DEF    = 64;
    localparam int ACTIONS_DEF   = 8;
    localparam int MAX_TRACE_DEF = 8;
    localparam int WINDOW_DEF    = 1024;

    localparam int STATE_W   = 6;
    localparam int ACTION_W  = 3;
    localparam int VALUE_W   = 32;
    localparam int FRAC_W    = 17;
    localparam int DRAW_W    = 16;
    localparam int SUM_W     = 48;
    localparam int COUNT_W   = 11;
    localparam int TRACE_W   = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [FRAC_W-1:0] ONE = 17'd65536;

    localparam logic [1:0] CMD_LEARN   = 2'd0;
    localparam logic [1:0] CMD_SELECT  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLORATION  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRACE_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRACE_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_USE_SARSA    = 3'd5;

    localparam logic [FRAC_W-1:0]  LEARN_RATE_RST   = 17'd6554;
    localparam logic [FRAC_W-1:0]  DISCOUNT_RST     = 17'd58982;
    localparam logic [FRAC_W-1:0]  EXPLORATION_RST  = 17'd3277;
    localparam logic [TRACE_W-1:0] TRACE_LENGTH_RST = 4'd1;
    localparam logic [FRAC_W-1:0]  TRACE_STEP_RST   = 17'd65536;

    typedef struct packed {
        logic [1:0]                cmd;
        logic [STATE_W-1:0]        state;
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] reward;
        logic [FRAC_W-1:0]         rate_factor;
        logic [DRAW_W-1:0]         explore_draw;
        logic [ACTION_W-1:0]       random_action;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] action_value;
        logic [ACTION_W-1:0]       chosen_action;
        logic                      explored;
        logic signed [SUM_W-1:0]   reward_sum;
        logic [COUNT_W-1:0]        reward_count;
    } result_t;

    typedef struct packed {
        logic                      push;
        logic                      restart;
        logic signed [VALUE_W-1:0] reward;
    } win_ctl_t;

    typedef struct packed {
        logic                    busy;
        logic signed [SUM_W-1:0] sum;
        logic [COUNT_W-1:0]      count;
    } win_stat_t;

endpackage

@@ rtl/qtls_window.sv @@
`timescale 1ns / 1ps
module qtls_window #(
    parameter int WINDOW = qtls_pkg::WINDOW_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  qtls_pkg::win_ctl_t  ctl,
    output qtls_pkg::win_stat_t stat
);
    import qtls_pkg::*;

    localparam int WW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);

    logic signed [VALUE_W-1:0] win_mem [WINDOW];
    logic signed [VALUE_W-1:0] old_reg;
    logic signed [VALUE_W-1:0] new_reg;
    logic                      pend_reg;
    logic                      busy_reg;
    logic [WW-1:0]             clr_reg;
    logic [WW-1:0]             wp_reg;
    logic [CW-1:0]             steps_reg;
    logic signed [SUM_W-1:0]   sum_reg;

    // Old entry comes out while the new reward goes in at the same slot.
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            win_mem[clr_reg] <= '0;
        end
        else if (ctl.push)
        begin
            old_reg          <= win_mem[wp_reg];
            win_mem[wp_reg]  <= ctl.reward;
            new_reg          <= ctl.reward;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            wp_reg    <= '0;
            steps_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            if (busy_reg)
            begin
                clr_reg <= clr_reg + 1'b1;
                if (clr_reg == WW'(WINDOW - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
            pend_reg <= ctl.push && !busy_reg;
            if (pend_reg)
            begin
                sum_reg <= sum_reg - SUM_W'(old_reg) + SUM_W'(new_reg);
            end
            if (ctl.restart)
            begin
                wp_reg    <= '0;
                steps_reg <= '0;
            end
            else if (ctl.push)
            begin
                wp_reg <= (wp_reg == WW'(WINDOW - 1)) ? '0 : wp_reg + 1'b1;
                if (steps_reg != CW'(WINDOW))
                begin
                    steps_reg <= steps_reg + 1'b1;
                end
            end
        end
    end

    assign stat.busy  = busy_reg;
    assign stat.sum   = sum_reg;
    assign stat.count = COUNT_W'(steps_reg);

endmodule

@@ rtl/q_table_learn_select.sv @@
`timescale 1ns / 1ps
// Select scans the row, then reads the chosen entry; restart goes straight to the result.
// Learn replays L steps, scanning N entries per step, N = ACTIONS for the row-max
// target or 1 for SARSA; the Q memory's single read port scans the row.
// One item in flight at a time; a finished result waits in the output register.
// Reset loads config defaults and clears pointers and counts, then a clearing
// pass zeroes the Q table and reward window.
module q_table_learn_select #(
    parameter int STATES    = qtls_pkg::STATES_DEF,
    parameter int ACTIONS   = qtls_pkg::ACTIONS_DEF,
    parameter int MAX_TRACE = qtls_pkg::MAX_TRACE_DEF,
    parameter int WINDOW    = qtls_pkg::WINDOW_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [qtls_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qtls_pkg::FRAC_W-1:0]          cfg_data,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  qtls_pkg::item_t                      item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output qtls_pkg::result_t                    result
);
    import qtls_pkg::*;

    localparam int SW   = (STATES > 1) ? $clog2(STATES) : 1;
    localparam int AW   = $clog2(ACTIONS);
    localparam int QN   = STATES * ACTIONS;
    localparam int QAW  = $clog2(QN);
    localparam int RING = MAX_TRACE + 1;
    localparam int RW   = $clog2(RING);
    localparam int PW   = RW + 1;
    localparam int HCW  = $clog2(MAX_TRACE + 1);
    localparam int ICW  = $clog2(MAX_TRACE + 2);
    localparam int KW   = $clog2(ACTIONS + 1);
    localparam int HW   = SW + AW + VALUE_W;
    localparam int GP_W   = 50;
    localparam int DIFF_W = 36;
    localparam int PROD_W = 54;
    localparam int NQ_W   = 39;
    localparam logic signed [NQ_W-1:0] QMAX = 39'sd2147483647;
    localparam logic signed [NQ_W-1:0] QMIN = -39'sd2147483648;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHK, S_H0, S_H1, S_SCAN, S_QRD, S_QW,
        S_DIFF, S_PROD, S_WB, S_FIN, S_FINW, S_SELD, S_SELW, S_RES
    } state_t;

    function automatic logic [FRAC_W-1:0] cap_one(input logic [FRAC_W-1:0] v);
        return (v > ONE) ? ONE : v;
    endfunction

    function automatic logic [QAW-1:0] qaddr(input logic [SW-1:0] s, input logic [AW-1:0] a);
        return QAW'(s) * QAW'(ACTIONS) + QAW'(a);
    endfunction

    state_t state_reg;

    logic [FRAC_W-1:0]  learn_rate_reg, discount_reg, exploration_reg, trace_step_reg;
    logic [TRACE_W-1:0] trace_length_reg;
    logic               use_sarsa_reg;

    logic [QAW-1:0]     clr_reg;
    logic [RW-1:0]      rp_reg;
    logic [HCW-1:0]     hcnt_reg;
    logic [ICW-1:0]     i_reg, len_reg;
    logic [RW-1:0]      p0_reg;
    logic [FRAC_W-1:0]  f_reg, lr_reg, gm_reg, rf_reg, rate1_reg, rate_reg;
    logic [SW-1:0]      s_reg, s0_reg;
    logic [AW-1:0]      a_reg, a0_reg, ra_reg, best_idx_reg, chosen_reg;
    logic               explore_reg, sel_reg, scan_one_reg;
    logic signed [VALUE_W-1:0] r0_reg, q_reg, best_reg;
    logic [KW-1:0]      scan_k_reg;
    logic [QAW-1:0]     scan_base_reg;
    logic signed [GP_W-1:0]   gnext_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic               result_valid_reg;
    result_t            result_reg;

    logic signed [VALUE_W-1:0] q_mem [QN];
    logic signed [VALUE_W-1:0] q_rd_reg;
    logic [HW-1:0]             hist_mem [RING];
    logic [HW-1:0]             hist_rd_reg;

    logic                      q_re, q_we, hist_re, hist_we;
    logic [QAW-1:0]            q_raddr, q_waddr;
    logic signed [VALUE_W-1:0] q_wdata;
    logic [RW-1:0]             hist_raddr;

    logic [SW-1:0]  st_wrap [2**STATE_W];
    logic [AW-1:0]  ac_wrap [2**ACTION_W];
    logic [SW-1:0]  s_in;
    logic [AW-1:0]  a_in, ra_in, chosen_next;
    logic           accept, can_load, scan_take, res_load;
    logic [KW-1:0]  scan_n;
    logic [PW-1:0]  p0_wide;
    logic [RW-1:0]  p0_next, p1_next;
    logic [ICW-1:0] len_next;
    logic [2*FRAC_W-1:0] rate1_prod, rate_prod;
    logic signed [GP_W-1:0]   gprod;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [NQ_W-1:0]   nq_sum;
    logic signed [VALUE_W-1:0] newq_next;
    win_ctl_t  win_ctl;
    win_stat_t win_stat;

    for (genvar g = 0; g < 2**STATE_W; g++)
    begin : g_st_wrap
        assign st_wrap[g] = SW'(g % STATES);
    end
    for (genvar g = 0; g < 2**ACTION_W; g++)
    begin : g_ac_wrap
        assign ac_wrap[g] = AW'(g % ACTIONS);
    end

    assign s_in  = st_wrap[item.state];
    assign a_in  = ac_wrap[item.action];
    assign ra_in = ac_wrap[item.random_action];

    assign item_stall = (state_reg != S_IDLE) || win_stat.busy;
    assign accept     = item_valid && !item_stall;
    assign can_load   = !result_valid_reg || !result_stall;
    assign res_load   = can_load && ((state_reg == S_FINW) || (state_reg == S_SELW) ||
                                     (state_reg == S_RES));

    assign len_next = (trace_length_reg == '0) ? ICW'(1) :
                      ((int'(trace_length_reg) > MAX_TRACE) ? ICW'(MAX_TRACE) :
                       ICW'(trace_length_reg));

    assign p0_wide = PW'(rp_reg) + PW'(RING) - PW'(i_reg);
    assign p0_next = (p0_wide >= PW'(RING)) ? RW'(p0_wide - PW'(RING)) : RW'(p0_wide);
    assign p1_next = (p0_reg == RW'(RING - 1)) ? '0 : p0_reg + 1'b1;

    assign scan_n    = scan_one_reg ? KW'(1) : KW'(ACTIONS);
    assign scan_take = (scan_k_reg == KW'(1)) || (q_rd_reg > best_reg);
    assign chosen_next = explore_reg ? ra_reg : best_idx_reg;

    assign rate1_prod = lr_reg * f_reg;
    assign rate_prod  = rate1_reg * rf_reg;
    assign gprod      = $signed({1'b0, gm_reg}) * best_reg;
    assign diff_next  = DIFF_W'(r0_reg) + DIFF_W'(gnext_reg >>> 16) - DIFF_W'(q_reg);
    assign prod_next  = $signed({1'b0, rate_reg}) * diff_reg;
    assign nq_sum     = NQ_W'(q_reg) + NQ_W'(prod_reg >>> 16);
    assign newq_next  = (nq_sum > QMAX) ? VALUE_W'(QMAX) :
                        ((nq_sum < QMIN) ? VALUE_W'(QMIN) : VALUE_W'(nq_sum));

    assign hist_we = accept && (item.cmd == CMD_LEARN);

    assign win_ctl.push    = accept && (item.cmd == CMD_LEARN);
    assign win_ctl.restart = accept && (item.cmd == CMD_RESTART);
    assign win_ctl.reward  = item.reward;

    qtls_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (win_ctl),
        .stat  (win_stat)
    );

    always_comb
    begin
        q_re       = 1'b0;
        q_raddr    = '0;
        q_we       = 1'b0;
        q_waddr    = '0;
        q_wdata    = '0;
        hist_re    = 1'b0;
        hist_raddr = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                q_we    = 1'b1;
                q_waddr = clr_reg;
            end
            S_CHK:
            begin
                hist_re    = 1'b1;
                hist_raddr = p0_next;
            end
            S_H0:
            begin
                hist_re    = 1'b1;
                hist_raddr = p1_next;
            end
            S_SCAN:
            begin
                if (scan_k_reg < scan_n)
                begin
                    q_re    = 1'b1;
                    q_raddr = scan_one_reg ? scan_base_reg
                                           : scan_base_reg + QAW'(scan_k_reg);
                end
            end
            S_QRD:
            begin
                q_re    = 1'b1;
                q_raddr = qaddr(s0_reg, a0_reg);
            end
            S_WB:
            begin
                q_we    = 1'b1;
                q_waddr = qaddr(s0_reg, a0_reg);
                q_wdata = newq_next;
            end
            S_FIN:
            begin
                q_re    = 1'b1;
                q_raddr = qaddr(s_reg, a_reg);
            end
            S_SELD:
            begin
                q_re    = 1'b1;
                q_raddr = qaddr(s_reg, chosen_next);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_waddr] <= q_wdata;
        end
        if (q_re)
        begin
            q_rd_reg <= q_mem[q_raddr];
        end
        if (hist_we)
        begin
            hist_mem[rp_reg] <= {s_in, a_in, item.reward};
        end
        if (hist_re)
        begin
            hist_rd_reg <= hist_mem[hist_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            learn_rate_reg   <= LEARN_RATE_RST;
            discount_reg     <= DISCOUNT_RST;
            exploration_reg  <= EXPLORATION_RST;
            trace_length_reg <= TRACE_LENGTH_RST;
            trace_step_reg   <= TRACE_STEP_RST;
            use_sarsa_reg    <= 1'b0;
            clr_reg          <= '0;
            rp_reg           <= '0;
            hcnt_reg         <= '0;
            i_reg            <= '0;
            scan_k_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LEARN_RATE:   learn_rate_reg   <= cfg_data;
                    REG_DISCOUNT:     discount_reg     <= cfg_data;
                    REG_EXPLORATION:  exploration_reg  <= cfg_data;
                    REG_TRACE_LENGTH: trace_length_reg <= cfg_data[TRACE_W-1:0];
                    REG_TRACE_STEP:   trace_step_reg   <= cfg_data;
                    REG_USE_SARSA:    use_sarsa_reg    <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            if (res_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == QAW'(QN - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        s_reg       <= s_in;
                        a_reg       <= a_in;
                        ra_reg      <= ra_in;
                        explore_reg <= {1'b0, item.explore_draw} < exploration_reg;
                        unique case (item.cmd)
                            CMD_LEARN:
                            begin
                                lr_reg    <= cap_one(learn_rate_reg);
                                gm_reg    <= cap_one(discount_reg);
                                rf_reg    <= cap_one(item.rate_factor);
                                len_reg   <= len_next;
                                f_reg     <= ONE;
                                i_reg     <= ICW'(1);
                                sel_reg   <= 1'b0;
                                state_reg <= S_CHK;
                            end
                            CMD_SELECT:
                            begin
                                sel_reg       <= 1'b1;
                                scan_one_reg  <= 1'b0;
                                scan_base_reg <= qaddr(s_in, '0);
                                scan_k_reg    <= '0;
                                state_reg     <= S_SCAN;
                            end
                            CMD_RESTART:
                            begin
                                rp_reg    <= '0;
                                hcnt_reg  <= '0;
                                state_reg <= S_RES;
                            end
                            default:
                            begin
                                state_reg <= S_RES;
                            end
                        endcase
                    end
                end
                S_CHK:
                begin
                    // Stop at the trace length or where history runs out.
                    if ((i_reg > len_reg) || (i_reg > ICW'(hcnt_reg)))
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        p0_reg    <= p0_next;
                        rate1_reg <= FRAC_W'(rate1_prod >> 16);
                        state_reg <= S_H0;
                    end
                end
                S_H0:
                begin
                    s0_reg    <= hist_rd_reg[HW-1 -: SW];
                    a0_reg    <= hist_rd_reg[VALUE_W +: AW];
                    r0_reg    <= hist_rd_reg[VALUE_W-1:0];
                    rate_reg  <= FRAC_W'(rate_prod >> 16);
                    state_reg <= S_H1;
                end
                S_H1:
                begin
                    scan_one_reg  <= use_sarsa_reg;
                    scan_base_reg <= use_sarsa_reg
                                   ? qaddr(hist_rd_reg[HW-1 -: SW], hist_rd_reg[VALUE_W +: AW])
                                   : qaddr(hist_rd_reg[HW-1 -: SW], '0);
                    scan_k_reg    <= '0;
                    state_reg     <= S_SCAN;
                end
                S_SCAN:
                begin
                    // Reads run one ahead of the compare; lowest index wins ties.
                    if ((scan_k_reg != '0) && scan_take)
                    begin
                        best_reg     <= q_rd_reg;
                        best_idx_reg <= AW'(scan_k_reg - 1'b1);
                    end
                    scan_k_reg <= scan_k_reg + 1'b1;
                    if (scan_k_reg == scan_n)
                    begin
                        state_reg <= sel_reg ? S_SELD : S_QRD;
                    end
                end
                S_QRD:
                begin
                    state_reg <= S_QW;
                end
                S_QW:
                begin
                    q_reg     <= q_rd_reg;
                    gnext_reg <= gprod;
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    diff_reg  <= diff_next;
                    state_reg <= S_PROD;
                end
                S_PROD:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    f_reg     <= (f_reg > trace_step_reg) ? f_reg - trace_step_reg : '0;
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= S_CHK;
                end
                S_FIN:
                begin
                    rp_reg <= (rp_reg == RW'(RING - 1)) ? '0 : rp_reg + 1'b1;
                    if (hcnt_reg != HCW'(MAX_TRACE))
                    begin
                        hcnt_reg <= hcnt_reg + 1'b1;
                    end
                    state_reg <= S_FINW;
                end
                S_FINW:
                begin
                    if (can_load)
                    begin
                        result_reg.action_value  <= q_rd_reg;
                        result_reg.chosen_action <= '0;
                        result_reg.explored      <= 1'b0;
                        result_reg.reward_sum    <= win_stat.sum;
                        result_reg.reward_count  <= win_stat.count;
                        state_reg                <= S_IDLE;
                    end
                end
                S_SELD:
                begin
                    chosen_reg <= chosen_next;
                    state_reg  <= S_SELW;
                end
                S_SELW:
                begin
                    if (can_load)
                    begin
                        result_reg.action_value  <= q_rd_reg;
                        result_reg.chosen_action <= ACTION_W'(chosen_reg);
                        result_reg.explored      <= explore_reg;
                        result_reg.reward_sum    <= win_stat.sum;
                        result_reg.reward_count  <= win_stat.count;
                        state_reg                <= S_IDLE;
                    end
                end
                S_RES:
                begin
                    if (can_load)
                    begin
                        result_reg.action_value  <= '0;
                        result_reg.chosen_action <= '0;
                        result_reg.explored      <= 1'b0;
                        result_reg.reward_sum    <= win_stat.sum;
                        result_reg.reward_count  <= win_stat.count;
                        state_reg                <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ rtl/qtls_checker.sv @@
`timescale 1ns / 1ps
`include "q_table_learn_select_assert.svh"
module qtls_checker (
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_stall,
    input logic result_valid,
    input logic result_stall
);

    // Keep result_valid high while a result is stalled.
    `QTLS_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid)

    // One item at a time: busy right after an accept.
    `QTLS_ASSERT_NXT(a_busy_after_accept, item_valid && !item_stall, item_stall)

    // A result only comes out of work in progress.
    `QTLS_ASSERT_IMP(a_result_from_work, $rose(result_valid), $past(item_stall))

endmodule

bind q_table_learn_select qtls_checker u_qtls_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall)
);
